[rtl/emboss_shade_window_core_assert.svh]
`ifndef EMBOSS_SHADE_WINDOW_CORE_ASSERT_SVH
`define EMBOSS_SHADE_WINDOW_CORE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define ESW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ESW_NEVER(label, cond, msg) \
   `ESW_ASSERT(label, !(cond), msg)

`endif

[rtl/esw_pkg.sv]
`default_nettype none
package esw_pkg;

   localparam int GradW  = 19;
   localparam int DotW   = 34;
   localparam int SumW   = 37;
   localparam int AccW   = 72;
   localparam int NumW   = 70;
   localparam int QuoW   = 32;
   localparam int RootW  = 16;
   localparam int MulW   = 20;
   localparam int StepW  = 7;

   localparam logic [1:0] CSR_LIGHT_X  = 2'd0;
   localparam logic [1:0] CSR_LIGHT_Y  = 2'd1;
   localparam logic [1:0] CSR_LIGHT_Z  = 2'd2;
   localparam logic [1:0] CSR_NORMAL_Z = 2'd3;

   localparam logic [15:0] LIGHT_X_RST  = 16'd22819;
   localparam logic [15:0] LIGHT_Y_RST  = 16'd4024;
   localparam logic [14:0] LIGHT_Z_RST  = 15'd23170;
   localparam logic [15:0] NORMAL_Z_RST = 16'd3277;

   typedef struct packed {
      logic        row_start;
      logic [15:0] top_luma;
      logic [15:0] top_alpha;
      logic [15:0] mid_luma;
      logic [15:0] mid_alpha;
      logic [15:0] bot_luma;
      logic [15:0] bot_alpha;
   } req_type;

   typedef struct packed {
      logic [15:0] shade;
      logic [15:0] centre_alpha;
   } rsp_type;

   typedef struct packed {
      logic signed [GradW-1:0] nx;
      logic signed [GradW-1:0] ny;
      logic [15:0]             alpha;
   } grad_type;

   typedef struct packed {
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic [14:0]        light_z;
      logic [15:0]        normal_z;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_ROOT,
      BK_DONE
   } back_state_type;

endpackage
`default_nettype wire

[rtl/emboss_shade_window_core.sv]
// A flat window's result skips the shading math; a window facing away from the light
// ends once its dot product is known; any other goes through the multiply, divide and root steps.
// Items that give no result are taken every cycle while the queue is not full; the shading
// unit handles one window at a time, and a 2-entry queue buffers waiting windows.
// Reset (synchronous, active high) clears the window, queue and output and
// loads the default light and normal registers.
`default_nettype none
`include "emboss_shade_window_core_assert.svh"
module emboss_shade_window_core
   import esw_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type          cfg_ff, cfg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             accept, push, pop, bk_done, out_free;
   grad_type         grad, head;
   queue_status_type qst;
   rsp_type          bk_result;

   assign accept = req_valid && req_ready;
   assign req_ready = !qst.full;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   esw_front u_front (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_data),
      .push  (push),
      .grad  (grad)
   );

   esw_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_data(grad),
      .pop    (pop),
      .rd_data(head),
      .status (qst)
   );

   esw_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .head    (head),
      .qst     (qst),
      .pop     (pop),
      .out_free(out_free),
      .done    (bk_done),
      .result  (bk_result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LIGHT_X:  cfg_in.light_x = csr_wdata;
            CSR_LIGHT_Y:  cfg_in.light_y = csr_wdata;
            CSR_LIGHT_Z:  cfg_in.light_z = csr_wdata[14:0];
            CSR_NORMAL_Z: cfg_in.normal_z = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (bk_done) begin
         rsp_valid_in = 1'b1;
         rsp_in = bk_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_x <= LIGHT_X_RST;
         cfg_ff.light_y <= LIGHT_Y_RST;
         cfg_ff.light_z <= LIGHT_Z_RST;
         cfg_ff.normal_z <= NORMAL_Z_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   `ESW_NEVER(a_push_when_full, push && qst.full, "window pushed into a full queue")
   `ESW_NEVER(a_pop_when_empty, pop && qst.empty, "window popped from an empty queue")
   `ESW_NEVER(a_result_overwrite, bk_done && rsp_valid_ff && !rsp_ready, "pending item overwritten")

endmodule
`default_nettype wire

[rtl/esw_front.sv]
`default_nettype none
module esw_front
   import esw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire req_type  req,
   output logic          push,
   output grad_type      grad
);

   logic [15:0] left_ff [3];
   logic [15:0] mid_ff [3];
   logic [15:0] left_in [3];
   logic [15:0] mid_in [3];
   logic [15:0] malpha_ff, malpha_in;
   logic [1:0]  seen_ff, seen_in;
   logic [1:0]  seen_eff;
   logic [15:0] cur [3];
   logic [31:0] p0, p1, p2;

   function automatic logic signed [GradW-1:0] ext(input logic [15:0] v);
      return $signed({{(GradW-16){1'b0}}, v});
   endfunction

   always_comb begin
      p0 = 32'(req.top_luma) * 32'(req.top_alpha);
      p1 = 32'(req.mid_luma) * 32'(req.mid_alpha);
      p2 = 32'(req.bot_luma) * 32'(req.bot_alpha);
      cur[0] = p0[31:16];
      cur[1] = p1[31:16];
      cur[2] = p2[31:16];
      seen_eff = req.row_start ? 2'd0 : seen_ff;
      grad.nx = ext(left_ff[0]) + ext(mid_ff[0]) + ext(cur[0])
              - ext(left_ff[2]) - ext(mid_ff[2]) - ext(cur[2]);
      grad.ny = ext(cur[0]) + ext(cur[1]) + ext(cur[2])
              - ext(left_ff[0]) - ext(left_ff[1]) - ext(left_ff[2]);
      grad.alpha = malpha_ff;
      push = accept && (seen_eff == 2'd2);
      left_in = left_ff;
      mid_in = mid_ff;
      malpha_in = malpha_ff;
      seen_in = seen_ff;
      if (accept) begin
         left_in = mid_ff;
         mid_in = cur;
         malpha_in = req.mid_alpha;
         seen_in = (seen_eff == 2'd2) ? 2'd2 : seen_eff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 2'd0;
         malpha_ff <= 16'd0;
         for (int i = 0; i < 3; i++) begin
            left_ff[i] <= 16'd0;
            mid_ff[i] <= 16'd0;
         end
      end else begin
         seen_ff <= seen_in;
         malpha_ff <= malpha_in;
         left_ff <= left_in;
         mid_ff <= mid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/esw_queue.sv]
`default_nettype none
module esw_queue
   import esw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire grad_type   wr_data,
   input  wire logic       pop,
   output grad_type        rd_data,
   output queue_status_type status
);

   grad_type    mem_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      status.full = (cnt_ff == 2'd2);
      status.empty = (cnt_ff == 2'd0);
      rd_data = mem_ff[rd_ff];
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[rtl/esw_back.sv]
`default_nettype none
module esw_back
   import esw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire grad_type         head,
   input  wire queue_status_type qst,
   output logic                  pop,
   input  wire logic             out_free,
   output logic                  done,
   output rsp_type               result
);

   back_state_type state_ff, state_in;
   logic [StepW-1:0]        step_ff, step_in;
   logic signed [GradW-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [15:0]             alpha_ff, alpha_in;
   logic signed [AccW-1:0]  acc_ff, acc_in;
   logic [DotW-1:0]         dot_ff, dot_in;
   logic [SumW-1:0]         s_ff, s_in;
   logic [SumW-1:0]         rem_ff, rem_in;
   logic [QuoW-1:0]         quo_ff, quo_in;
   logic                    sat_ff, sat_in;
   logic [RootW-1:0]        root_ff, root_in;
   logic [15:0]             shade_ff, shade_in;

   logic signed [MulW-1:0]   ma, mb;
   logic signed [2*MulW-1:0] prod;
   logic signed [AccW-1:0]   pext;
   logic [SumW:0]            rem_sh, rem_sub;
   logic                     ge;
   logic [RootW-1:0]         trial;
   logic [2*RootW-1:0]       sq;
   logic [16:0]              dot_a, dot_b;

   always_comb begin
      dot_a = dot_ff[DotW-1:17];
      dot_b = dot_ff[16:0];
      case (step_ff[3:0])
         4'd0: begin ma = MulW'(nx_ff); mb = MulW'(cfg.light_x); end
         4'd1: begin ma = MulW'(ny_ff); mb = MulW'(cfg.light_y); end
         4'd2: begin ma = $signed(MulW'(cfg.normal_z)); mb = $signed(MulW'(cfg.light_z)); end
         4'd3: begin ma = MulW'(nx_ff); mb = MulW'(nx_ff); end
         4'd4: begin ma = MulW'(ny_ff); mb = MulW'(ny_ff); end
         4'd5: begin ma = $signed(MulW'(cfg.normal_z)); mb = $signed(MulW'(cfg.normal_z)); end
         4'd6: begin ma = $signed(MulW'(dot_a)); mb = $signed(MulW'(dot_a)); end
         4'd7: begin ma = $signed(MulW'(dot_a)); mb = $signed(MulW'(dot_b)); end
         4'd8: begin ma = $signed(MulW'(dot_b)); mb = $signed(MulW'(dot_b)); end
         default: begin ma = '0; mb = '0; end
      endcase
      prod = ma * mb;
      pext = AccW'(prod);

      rem_sh = {rem_ff, acc_ff[NumW-1]};
      rem_sub = rem_sh - {1'b0, s_ff};
      ge = (rem_sh >= {1'b0, s_ff});

      trial = root_ff | (RootW'(1) << step_ff[3:0]);
      sq = (2*RootW)'(trial) * (2*RootW)'(trial);

      state_in = state_ff;
      step_in = step_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      alpha_in = alpha_ff;
      acc_in = acc_ff;
      dot_in = dot_ff;
      s_in = s_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      sat_in = sat_ff;
      root_in = root_ff;
      shade_in = shade_ff;
      pop = 1'b0;
      done = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!qst.empty) begin
               pop = 1'b1;
               nx_in = head.nx;
               ny_in = head.ny;
               alpha_in = head.alpha;
               step_in = '0;
               if (head.nx == '0 && head.ny == '0) begin
                  shade_in = {cfg.light_z, 1'b0};
                  state_in = BK_DONE;
               end else begin
                  state_in = BK_MUL;
               end
            end
         end
         BK_MUL: begin
            step_in = step_ff + StepW'(1);
            case (step_ff[3:0])
               4'd0: acc_in = pext;
               4'd1, 4'd2: acc_in = acc_ff + pext;
               4'd3: begin
                  if (acc_ff[AccW-1]) begin
                     shade_in = 16'd0;
                     state_in = BK_DONE;
                  end
                  dot_in = acc_ff[DotW-1:0];
                  s_in = prod[SumW-1:0];
               end
               4'd4, 4'd5: s_in = s_ff + prod[SumW-1:0];
               4'd6: acc_in = pext <<< 36;
               4'd7: acc_in = acc_ff + (pext <<< 20);
               default: begin
                  acc_in = acc_ff + (pext <<< 2);
                  rem_in = '0;
                  quo_in = '0;
                  sat_in = 1'b0;
                  step_in = '0;
                  state_in = BK_DIV;
               end
            endcase
         end
         BK_DIV: begin
            acc_in = acc_ff <<< 1;
            rem_in = ge ? rem_sub[SumW-1:0] : rem_sh[SumW-1:0];
            quo_in = {quo_ff[QuoW-2:0], ge};
            sat_in = sat_ff | quo_ff[QuoW-1];
            step_in = step_ff + StepW'(1);
            if (step_ff == StepW'(NumW - 1)) begin
               root_in = '0;
               step_in = StepW'(RootW - 1);
               state_in = BK_ROOT;
            end
         end
         BK_ROOT: begin
            if (sat_ff || sq <= quo_ff) begin
               root_in = trial;
            end
            step_in = step_ff - StepW'(1);
            if (step_ff[3:0] == 4'd0) begin
               shade_in = (sat_ff || sq <= quo_ff) ? trial : root_ff;
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               done = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase

      result.shade = shade_ff;
      result.centre_alpha = alpha_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      nx_ff <= nx_in;
      ny_ff <= ny_in;
      alpha_ff <= alpha_in;
      acc_ff <= acc_in;
      dot_ff <= dot_in;
      s_ff <= s_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      root_ff <= root_in;
      shade_ff <= shade_in;
   end

endmodule
`default_nettype wire

[tb/tb_emboss_shade_window_core.sv]
`default_nettype none
module tb_emboss_shade_window_core;
   import esw_pkg::*;

   class shade_scoreboard;
      logic signed [15:0] light_x;
      logic signed [15:0] light_y;
      logic [14:0]        light_z;
      logic [15:0]        normal_z;
      logic [15:0]        left_prod[3];
      logic [15:0]        mid_prod[3];
      logic [15:0]        mid_alpha;
      int                 cols_held;
      rsp_type            shade_q[$];
      int                 errors;

      function new();
         light_x   = LIGHT_X_RST;
         light_y   = LIGHT_Y_RST;
         light_z   = LIGHT_Z_RST;
         normal_z  = NORMAL_Z_RST;
         for (int i = 0; i < 3; i++) begin
            left_prod[i] = '0;
            mid_prod[i]  = '0;
         end
         mid_alpha = '0;
         cols_held = 0;
         errors    = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            CSR_LIGHT_X:  light_x = val;
            CSR_LIGHT_Y:  light_y = val;
            CSR_LIGHT_Z:  light_z = val[14:0];
            CSR_NORMAL_Z: normal_z = val;
            default: ;
         endcase
      endfunction

      function logic [15:0] lambert(longint nx, longint ny);
         longint       dot;
         logic [127:0] num_sq;
         logic [127:0] norm_sq;
         logic [127:0] trial;
         logic [15:0]  root;
         if (nx == 0 && ny == 0) return {light_z, 1'b0};
         dot = nx * longint'(light_x) + ny * longint'(light_y)
             + longint'(normal_z) * longint'(light_z);
         if (dot < 0) return 16'd0;
         num_sq  = 128'(dot) * 128'(dot) * 128'd4;
         norm_sq = 128'(nx * nx) + 128'(ny * ny) + 128'(normal_z) * 128'(normal_z);
         root = '0;
         for (int b = 15; b >= 0; b--) begin
            trial = 128'(root | (16'd1 << b));
            if (trial * trial * norm_sq <= num_sq) root = root | (16'd1 << b);
         end
         return root;
      endfunction

      function void note_column(req_type d);
         logic [15:0] cur[3];
         logic [31:0] p;
         longint      nx;
         longint      ny;
         rsp_type     r;
         p = 32'(d.top_luma) * 32'(d.top_alpha);
         cur[0] = p[31:16];
         p = 32'(d.mid_luma) * 32'(d.mid_alpha);
         cur[1] = p[31:16];
         p = 32'(d.bot_luma) * 32'(d.bot_alpha);
         cur[2] = p[31:16];
         if (d.row_start) cols_held = 0;
         if (cols_held >= 2) begin
            nx = longint'(left_prod[0]) + mid_prod[0] + cur[0]
               - longint'(left_prod[2]) - mid_prod[2] - cur[2];
            ny = longint'(cur[0]) + cur[1] + cur[2]
               - longint'(left_prod[0]) - left_prod[1] - left_prod[2];
            r.shade        = lambert(nx, ny);
            r.centre_alpha = mid_alpha;
            shade_q.push_back(r);
         end
         for (int i = 0; i < 3; i++) begin
            left_prod[i] = mid_prod[i];
            mid_prod[i]  = cur[i];
         end
         mid_alpha = d.mid_alpha;
         if (cols_held < 2) cols_held++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (shade_q.size() == 0) begin
            $error("unexpected item: shade %0d centre_alpha %0d", got.shade, got.centre_alpha);
            errors++;
            return;
         end
         want = shade_q.pop_front();
         if (got.shade !== want.shade) begin
            $error("shade: expected %0d, actual %0d", want.shade, got.shade);
            errors++;
         end
         if (got.centre_alpha !== want.centre_alpha) begin
            $error("centre_alpha: expected %0d, actual %0d", want.centre_alpha,
                   got.centre_alpha);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   shade_scoreboard sb = new();
   int send_idle  = 0;
   int recv_stall = 0;
   int cycle_count = 0;

   emboss_shade_window_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic send_column(req_type d);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid <= 1'b1;
      req_data  <= d;
      do @(posedge clock); while (!req_ready);
      sb.note_column(d);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.shade_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic set_light(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
                            logic [15:0] nz);
      write_reg(CSR_LIGHT_X, lx);
      write_reg(CSR_LIGHT_Y, ly);
      write_reg(CSR_LIGHT_Z, lz);
      write_reg(CSR_NORMAL_Z, nz);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_type make_column(bit rs, logic [15:0] tl, logic [15:0] ta,
                                           logic [15:0] ml, logic [15:0] ma,
                                           logic [15:0] bl, logic [15:0] ba);
      req_type d;
      d.row_start = rs;
      d.top_luma = tl; d.top_alpha = ta;
      d.mid_luma = ml; d.mid_alpha = ma;
      d.bot_luma = bl; d.bot_alpha = ba;
      return d;
   endfunction

   task automatic random_rows(int n_items);
      int          len;
      bit          flat;
      logic [15:0] fl;
      logic [15:0] fa;
      bit          rs;
      int          sent;
      sent = 0;
      while (sent < n_items) begin
         len  = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 14);
         flat = ($urandom_range(5) == 0);
         fl   = pick_value();
         fa   = pick_value();
         for (int c = 0; c < len; c++) begin
            rs = (c == 0) || ($urandom_range(29) == 0);
            if (flat)
               send_column(make_column(rs, fl, fa, fl, fa, fl, fa));
            else
               send_column(make_column(rs, pick_value(), pick_value(), pick_value(),
                                       pick_value(), pick_value(), pick_value()));
            sent++;
         end
      end
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The first row starts without a row_start mark.
      for (int c = 0; c < 3; c++)
         send_column(make_column(1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0));
      for (int c = 0; c < 3; c++)
         send_column(make_column(c == 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF));
      for (int c = 0; c < 4; c++)
         send_column(make_column(c == 0, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h1234,
                                 16'd0, 16'hFFFF));
      send_column(make_column(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0));
      send_column(make_column(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      for (int c = 0; c < 3; c++)
         send_column(make_column(c == 0, 16'd0, 16'd0, 16'h00FF, 16'hABCD,
                                 16'hFFFF, 16'hFFFF));
      for (int c = 0; c < 3; c++)
         send_column(make_column(c == 0, 16'(16'h1000 * c), 16'hFFFF, 16'd0, 16'hFFFF,
                                 16'd0, 16'hFFFF));
      drain();

      set_light(16'h8000, 16'h7FFF, 16'h7FFF, 16'd0);
      for (int c = 0; c < 3; c++)
         send_column(make_column(c == 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h5555,
                                 16'd0, 16'd0));
      for (int c = 0; c < 3; c++)
         send_column(make_column(c == 0, 16'd0, 16'd0, 16'd0, 16'h00AA, 16'd0, 16'd0));
      random_rows(200);
      drain();

      set_light(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
      send_idle = 67;
      random_rows(100);
      drain();
      random_rows(100);
      drain();

      set_light(16'($urandom), 16'($urandom), 16'($urandom_range(32767)),
                16'($urandom_range(655, 65535)));
      send_idle  = 0;
      recv_stall = 67;
      random_rows(200);
      drain();

      set_light(16'd22819, 16'd4024, 16'd23170, 16'd655);
      send_idle  = 30;
      recv_stall = 30;
      random_rows(100);
      drain();
      send_idle  = 0;
      recv_stall = 0;
      random_rows(100);
      drain();

      if (sb.errors == 0 && sb.shade_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
`default_nettype wire

[emboss_shade_window_core.f]
+incdir+rtl
rtl/esw_pkg.sv
rtl/esw_front.sv
rtl/esw_queue.sv
rtl/esw_back.sv
rtl/emboss_shade_window_core.sv
tb/tb_emboss_shade_window_core.sv
